// ----- hw/rtl/h2df_pkg.sv -----
// Shared types and constants for the HTTP/2 frame deframer.
// Used by every module of the deframer; depends on nothing.
`timescale 1ns / 1ps

package h2df_pkg;

  localparam int unsigned HDR_BYTES = 9;
  localparam int unsigned CNT_W     = 4;

  // Byte positions inside the frame header.
  localparam logic [CNT_W-1:0] LEN_END   = 4'd3;
  localparam logic [CNT_W-1:0] TYPE_POS  = 4'd3;
  localparam logic [CNT_W-1:0] FLAGS_POS = 4'd4;
  localparam logic [CNT_W-1:0] HDR_LAST  = CNT_W'(HDR_BYTES - 1);

  localparam logic [7:0] LAST_KNOWN_TYPE = 8'd9;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        item_kind;
    logic [23:0] frame_length;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [31:0] stream_number;
    logic        type_known;
    logic [7:0]  payload_byte;
    logic        frame_last;
  } result_t;

endpackage

// ----- hw/rtl/h2df_if.sv -----
// Valid/ready channel interfaces for the deframer byte input and item output.
// Depends on nothing.
`timescale 1ns / 1ps

interface h2df_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface h2df_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [23:0] frame_length;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [31:0] stream_number;
  logic        type_known;
  logic [7:0]  payload_byte;
  logic        frame_last;

  modport source (output valid, output item_kind, output frame_length, output frame_type,
                  output frame_flags, output stream_number, output type_known,
                  output payload_byte, output frame_last, input ready);
  modport sink   (input valid, input item_kind, input frame_length, input frame_type,
                  input frame_flags, input stream_number, input type_known,
                  input payload_byte, input frame_last, output ready);
endinterface

// ----- hw/rtl/h2df_parse.sv -----
// Header collection and payload counting for the deframer.
// Depends on h2df_pkg.
`timescale 1ns / 1ps

module h2df_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        stream_byte,
  output logic              res_valid,
  output h2df_pkg::result_t res
);

  logic                          in_payload_r, in_payload_nxt;
  logic [h2df_pkg::CNT_W-1:0]    hdr_cnt_r, hdr_cnt_nxt;
  logic [23:0]                   rem_r, rem_nxt;
  logic [23:0]                   len_r, len_nxt;
  logic [7:0]                    type_r, type_nxt;
  logic [7:0]                    flags_r, flags_nxt;
  logic [31:0]                   stream_r, stream_nxt;
  logic                          pay_last;
  logic                          hdr_done;

  assign pay_last = (rem_r <= 24'd1);
  assign hdr_done = !in_payload_r && (hdr_cnt_r == h2df_pkg::HDR_LAST);

  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    rem_nxt        = rem_r;
    len_nxt        = len_r;
    type_nxt       = type_r;
    flags_nxt      = flags_r;
    stream_nxt     = stream_r;
    if (in_payload_r) begin
      rem_nxt = rem_r - 24'd1;
      if (pay_last) begin
        in_payload_nxt = 1'b0;
        rem_nxt        = '0;
      end
    end else begin
      priority if (hdr_cnt_r < h2df_pkg::LEN_END) begin
        len_nxt = {len_r[15:0], stream_byte};
      end else if (hdr_cnt_r == h2df_pkg::TYPE_POS) begin
        type_nxt = stream_byte;
      end else if (hdr_cnt_r == h2df_pkg::FLAGS_POS) begin
        flags_nxt = stream_byte;
      end else begin
        stream_nxt = {stream_r[23:0], stream_byte};
      end
      if (hdr_done) begin
        hdr_cnt_nxt = '0;
        if (len_nxt != 24'd0) begin
          in_payload_nxt = 1'b1;
          rem_nxt        = len_nxt;
        end
      end else begin
        hdr_cnt_nxt = hdr_cnt_r + 1'b1;
      end
    end
  end

  // The header beat reports the fields including the byte arriving now.
  always_comb begin
    res_valid         = accept && (in_payload_r || hdr_done);
    res.frame_length  = len_nxt;
    res.frame_type    = type_nxt;
    res.frame_flags   = flags_nxt;
    res.stream_number = stream_nxt;
    res.type_known    = (type_nxt <= h2df_pkg::LAST_KNOWN_TYPE);
    if (in_payload_r) begin
      res.item_kind    = h2df_pkg::KIND_PAYLOAD;
      res.payload_byte = stream_byte;
      res.frame_last   = pay_last;
    end else begin
      res.item_kind    = h2df_pkg::KIND_HEADER;
      res.payload_byte = 8'd0;
      res.frame_last   = (len_nxt == 24'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_cnt_r    <= '0;
      rem_r        <= '0;
    end else if (accept) begin
      in_payload_r <= in_payload_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      rem_r        <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      len_r    <= len_nxt;
      type_r   <= type_nxt;
      flags_r  <= flags_nxt;
      stream_r <= stream_nxt;
    end
  end

  a_cnt_idle_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (hdr_cnt_r == '0))
    else $error("header count not cleared while passing payload");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (rem_r != 24'd0))
    else $error("payload phase with no bytes remaining");

  a_enter_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && hdr_done && (len_nxt != 24'd0)) |=> (in_payload_r && rem_r == $past(len_nxt)))
    else $error("nonempty frame did not enter payload phase");

  a_leave_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_payload_r && pay_last) |=> (!in_payload_r && hdr_cnt_r == '0))
    else $error("last payload byte did not return to header collection");

endmodule

// ----- hw/rtl/h2df_out_reg.sv -----
// Result register between the deframer logic and the output channel.
// Depends on h2df_pkg.
`timescale 1ns / 1ps

module h2df_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  h2df_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              can_take,
  output h2df_pkg::result_t out_res
);

  logic              valid_r, valid_nxt;
  h2df_pkg::result_t data_r;

  // A new beat may enter in the same cycle the held one leaves.
  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = data_r;

endmodule

// ----- hw/rtl/http2_frame_deframer.sv -----
// HTTP/2 frame deframer: one stream byte per beat in, header and payload items out.
// A result appears on the output in the cycle after the byte that causes it.
// Throughput: one byte per cycle, limited only by output back-pressure.
// Reset (rst_n low, synchronous) clears the parser to header collection and empties
// the result register. Depends on h2df_pkg, h2df_if, h2df_parse and h2df_out_reg.
`timescale 1ns / 1ps

module http2_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  h2df_in_if.sink     in_ch,
  h2df_out_if.source  out_ch
);

  logic              in_fire;
  logic              res_valid;
  logic              can_take;
  h2df_pkg::result_t res;
  h2df_pkg::result_t out_res;

  assign in_ch.ready = can_take;
  assign in_fire     = in_ch.valid && can_take;

  h2df_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_fire),
    .stream_byte (in_ch.stream_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  h2df_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .can_take  (can_take),
    .out_res   (out_res)
  );

  assign out_ch.item_kind     = out_res.item_kind;
  assign out_ch.frame_length  = out_res.frame_length;
  assign out_ch.frame_type    = out_res.frame_type;
  assign out_ch.frame_flags   = out_res.frame_flags;
  assign out_ch.stream_number = out_res.stream_number;
  assign out_ch.type_known    = out_res.type_known;
  assign out_ch.payload_byte  = out_res.payload_byte;
  assign out_ch.frame_last    = out_res.frame_last;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for http2_frame_deframer: drives byte streams of HTTP/2 frames
// with random idle gaps and stalls, and checks each result item against a local deframer.
// Depends on h2df_pkg, h2df_if and the deframer RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RANDOM_BYTES = 630;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS  = 10;
  // Room a long frame needs so the run does not overshoot its byte budget.
  localparam int unsigned LONG_ROOM    = 300;

  typedef struct packed {
    logic [7:0]        stream_byte;
    logic              typed;
    h2df_pkg::result_t item;
  } stim_row_t;

  // Hand-written results for the directed frames.
  localparam h2df_pkg::result_t HDR_EMPTY_T9 = '{
    item_kind: h2df_pkg::KIND_HEADER, frame_length: 24'd0,
    frame_type: 8'd9, frame_flags: 8'h00,
    stream_number: 32'h0000_0000, type_known: 1'b1,
    payload_byte: 8'h00, frame_last: 1'b1};
  localparam h2df_pkg::result_t HDR_ONES = '{
    item_kind: h2df_pkg::KIND_HEADER, frame_length: 24'd1,
    frame_type: 8'h0A, frame_flags: 8'hFF,
    stream_number: 32'hFFFF_FFFF, type_known: 1'b0,
    payload_byte: 8'h00, frame_last: 1'b0};
  localparam h2df_pkg::result_t PAY_ONES = '{
    item_kind: h2df_pkg::KIND_PAYLOAD, frame_length: 24'd1,
    frame_type: 8'h0A, frame_flags: 8'hFF,
    stream_number: 32'hFFFF_FFFF, type_known: 1'b0,
    payload_byte: 8'hFF, frame_last: 1'b1};

  // First frame: empty payload, highest known type, all other fields zero.
  // Second frame: one payload byte, lowest unknown type, flags, stream number and payload byte all ones.
  localparam stim_row_t DIRECTED [19] = '{
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h09, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, HDR_EMPTY_T9},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'h0A, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, HDR_ONES},
    '{8'hFF, 1'b1, PAY_ONES}
  };

  logic clk = 1'b0;
  logic rst_n;

  h2df_in_if  in_ch ();
  h2df_out_if out_ch ();

  http2_frame_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Deframer state kept by the bench.
  bit          hdr_done;
  logic [3:0]  hdr_pos;
  logic [23:0] cur_length;
  logic [7:0]  cur_type;
  logic [7:0]  cur_flags;
  logic [31:0] cur_stream;
  logic [23:0] left_in_payload;

  h2df_pkg::result_t pending_items[$];
  int unsigned       mismatches;
  int unsigned       bytes_sent;
  int unsigned       frames_sent;
  int unsigned       header_items;
  int unsigned       payload_items;
  int unsigned       unknown_headers;

  function automatic h2df_pkg::result_t frame_item(logic kind, logic [7:0] pb, logic last);
    h2df_pkg::result_t r;
    r.item_kind     = kind;
    r.frame_length  = cur_length;
    r.frame_type    = cur_type;
    r.frame_flags   = cur_flags;
    r.stream_number = cur_stream;
    r.type_known    = (cur_type <= h2df_pkg::LAST_KNOWN_TYPE);
    r.payload_byte  = pb;
    r.frame_last    = last;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, output bit produced,
                              output h2df_pkg::result_t item);
    logic last;
    produced = 1'b0;
    item     = '0;
    if (hdr_done) begin
      last = (left_in_payload <= 24'd1);
      item = frame_item(h2df_pkg::KIND_PAYLOAD, b, last);
      produced = 1'b1;
      left_in_payload = left_in_payload - 24'd1;
      if (last) begin
        hdr_done        = 1'b0;
        left_in_payload = '0;
      end
    end else begin
      if (hdr_pos < h2df_pkg::LEN_END) cur_length = {cur_length[15:0], b};
      else if (hdr_pos == h2df_pkg::TYPE_POS) cur_type = b;
      else if (hdr_pos == h2df_pkg::FLAGS_POS) cur_flags = b;
      else cur_stream = {cur_stream[23:0], b};

      if (hdr_pos != h2df_pkg::HDR_LAST) begin
        hdr_pos = hdr_pos + 4'd1;
      end else begin
        hdr_pos  = '0;
        produced = 1'b1;
        if (cur_length == 24'd0) begin
          item = frame_item(h2df_pkg::KIND_HEADER, 8'h00, 1'b1);
        end else begin
          item            = frame_item(h2df_pkg::KIND_HEADER, 8'h00, 1'b0);
          hdr_done        = 1'b1;
          left_in_payload = cur_length;
        end
      end
    end
  endtask

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic string item_text(h2df_pkg::result_t r);
    return {$sformatf("kind=%0d len=%0d type=%02h flags=%02h ",
                      r.item_kind, r.frame_length, r.frame_type, r.frame_flags),
            $sformatf("stream=%08h known=%0d byte=%02h last=%0d",
                      r.stream_number, r.type_known, r.payload_byte, r.frame_last)};
  endfunction

  function automatic string field_diffs(h2df_pkg::result_t want, h2df_pkg::result_t seen);
    string s;
    s = "";
    if (seen.item_kind !== want.item_kind) s = {s, " item_kind"};
    if (seen.frame_length !== want.frame_length) s = {s, " frame_length"};
    if (seen.frame_type !== want.frame_type) s = {s, " frame_type"};
    if (seen.frame_flags !== want.frame_flags) s = {s, " frame_flags"};
    if (seen.stream_number !== want.stream_number) s = {s, " stream_number"};
    if (seen.type_known !== want.type_known) s = {s, " type_known"};
    if (seen.payload_byte !== want.payload_byte) s = {s, " payload_byte"};
    if (seen.frame_last !== want.frame_last) s = {s, " frame_last"};
    return s;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // One byte per call; valid stays high into the next beat unless a gap is chosen.
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input h2df_pkg::result_t typed_item, input bit calm);
    bit                produced;
    h2df_pkg::result_t item;
    int unsigned       gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 25) gap = idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.stream_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    deframe_byte(b, produced, item);
    if (typed) pending_items.push_back(typed_item);
    else if (produced) pending_items.push_back(item);
  endtask

  task automatic send_frame(input logic [23:0] len, input logic [7:0] ftype,
                            input logic [7:0] flags, input logic [31:0] sid, input bit calm);
    logic [71:0] hdr;
    hdr = {len, ftype, flags, sid};
    for (int i = 8; i >= 0; i--) send_byte(hdr[i*8 +: 8], 1'b0, '0, calm);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0, '0, calm);
    frames_sent++;
  endtask

  task automatic wait_all_results();
    while (pending_items.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, with calm stretches that toggle now and then.
  initial begin
    int unsigned stall_left;
    bit          calm_sink;
    stall_left   = 0;
    calm_sink    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
        stall_left = 0;
      end else begin
        if ($urandom_range(0, 63) == 0) calm_sink = !calm_sink;
        if (stall_left != 0) begin
          stall_left--;
          out_ch.ready <= (stall_left == 0);
        end else if (!calm_sink && $urandom_range(0, 99) < 20) begin
          stall_left = idle_len();
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    h2df_pkg::result_t seen;
    h2df_pkg::result_t want;
    string             bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{item_kind: out_ch.item_kind, frame_length: out_ch.frame_length,
               frame_type: out_ch.frame_type, frame_flags: out_ch.frame_flags,
               stream_number: out_ch.stream_number, type_known: out_ch.type_known,
               payload_byte: out_ch.payload_byte, frame_last: out_ch.frame_last};
      if (seen.item_kind == h2df_pkg::KIND_HEADER) begin
        header_items++;
        if (seen.type_known == 1'b0) unknown_headers++;
      end else begin
        payload_items++;
      end
      if (pending_items.size() == 0) begin
        note_mismatch({"unexpected result ", item_text(seen)});
      end else begin
        want = pending_items.pop_front();
        bad  = field_diffs(want, seen);
        if (bad != "")
          note_mismatch($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                                  header_items + payload_items, bad,
                                  item_text(want), item_text(seen)));
      end
    end
  end

  initial begin
    logic [23:0] len;
    logic [7:0]  ftype;
    logic [31:0] sid;
    bit          calm;
    int unsigned frame_no;

    hdr_done          = 1'b0;
    hdr_pos           = '0;
    cur_length        = '0;
    cur_type          = '0;
    cur_flags         = '0;
    cur_stream        = '0;
    left_in_payload   = '0;
    mismatches        = 0;
    bytes_sent        = 0;
    frames_sent       = 0;
    header_items      = 0;
    payload_items     = 0;
    unknown_headers   = 0;
    in_ch.valid       = 1'b0;
    in_ch.stream_byte = 8'h00;
    rst_n             = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].stream_byte, DIRECTED[i].typed, DIRECTED[i].item, 1'b0);
    frames_sent += 2;

    // Hold the sender until the directed frames have fully drained.
    in_ch.valid <= 1'b0;
    wait_all_results();

    frame_no = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      if ((frame_no == 10 || $urandom_range(0, 39) == 0) &&
          bytes_sent + LONG_ROOM < RANDOM_BYTES)
        len = 24'(256 + $urandom_range(0, 12));
      else if ($urandom_range(0, 4) == 0) len = 24'd0;
      else len = 24'($urandom_range(1, 20));
      if ($urandom_range(0, 99) < 70) ftype = 8'($urandom_range(0, 9));
      else ftype = 8'($urandom_range(10, 255));
      case ($urandom_range(0, 9))
        0:       sid = 32'h0000_0000;
        1:       sid = 32'h8000_0000 | $urandom_range(0, 15);
        default: sid = $urandom;
      endcase
      send_frame(len, ftype, 8'($urandom_range(0, 255)), sid, calm);
      frame_no++;
      if (frame_no % 12 == 0) begin
        in_ch.valid <= 1'b0;
        wait_all_results();
      end
    end

    in_ch.valid <= 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d frames; checked %0d headers (%0d of unknown type)",
             bytes_sent, frames_sent, header_items, unknown_headers);
    $display("and %0d payload bytes, %0d results left waiting", payload_items,
             pending_items.size());
    if (mismatches == 0 && pending_items.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Slowest legal run is well under a millisecond of simulated time.
  initial begin
    #4_000_000;
    $display("ERROR: run did not complete in time");
    $display("Mismatches found");
    $finish;
  end

endmodule
